[rtl/lbr_pkg.sv]
// Shared widths and result word type for the longest balanced run block.
package lbr_pkg;

    localparam int CODE_W  = 8;
    localparam int START_W = 10;
    localparam int LEN_W   = 11;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] run_start;
        logic [LEN_W-1:0]   run_length;
        logic               overflow;
    } t_result;

endpackage

[rtl/longest_balanced_odd_even_run_top.sv]
// Longest balanced odd/even run finder: first-seen balance table in one memory.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | i_valid / o_ready  | i_char_code[7:0], i_last
//  out     | o_valid / i_ready  | o_found, o_run_start[9:0], o_run_length[10:0],
//          |                    | o_overflow
//
// One character word per cycle while o_ready is high. Each word of the first
// MAX_LEN in a string makes one access to the first-seen memory (read if its
// balance was already reached, else write); the read data is checked in the
// next cycle. The check stage passes each result word to the result buffer.
// Up to two result words are buffered; o_ready drops while that buffer and the
// result in flight would fill it, unless a word leaves at the same edge. The
// seen marks are the range of balances reached so far, so no clearing pass is
// needed after reset or between strings. Reset is synchronous, active low.
module longest_balanced_odd_even_run_top #(
    parameter int MAX_LEN = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lbr_pkg::CODE_W-1:0]    i_char_code,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_found,
    output logic [lbr_pkg::START_W-1:0]   o_run_start,
    output logic [lbr_pkg::LEN_W-1:0]     o_run_length,
    output logic                          o_overflow
);

    localparam int PW    = $clog2(MAX_LEN + 1);     // position, holds MAX_LEN
    localparam int IW    = $clog2(MAX_LEN);         // index 0..MAX_LEN-1
    localparam int BW    = PW + 1;                  // signed balance
    localparam int DEPTH = 2 * MAX_LEN + 1;
    localparam int SW    = $clog2(DEPTH);

    // front stage state
    logic signed [BW-1:0] r_bal;
    logic signed [BW-1:0] r_lo;
    logic signed [BW-1:0] r_hi;
    logic                 r_any;
    logic [PW-1:0]        r_pos;
    logic                 r_too_long;

    // check stage
    logic          r_s1_valid;
    logic          r_s1_last;
    logic          r_s1_act;
    logic          r_s1_seen;
    logic          r_s1_zero;
    logic          r_s1_ovf;
    logic [IW-1:0] r_s1_pos;
    logic [IW-1:0] r_rd;

    logic [PW-1:0] r_best_len;
    logic [IW-1:0] r_best_start;

    // result buffer
    logic                 r_out_valid;
    logic                 r_skid_valid;
    lbr_pkg::t_result     r_out;
    lbr_pkg::t_result     r_skid;

    logic [IW-1:0] mem [DEPTH];

    logic                 w_accept;
    logic                 w_act;
    logic                 w_ovf;
    logic signed [BW-1:0] n_bal;
    logic                 w_seen;
    logic [BW-1:0]        w_slot_full;
    logic [SW-1:0]        w_slot;
    logic [IW-1:0]        w_pos_idx;
    logic [1:0]           w_pending;

    logic [PW-1:0]        w_len;
    logic [PW-1:0]        n_best_len;
    logic [IW-1:0]        n_best_start;
    logic                 w_push;
    logic                 w_pop;
    lbr_pkg::t_result     w_res;

    assign w_pending = {1'b0, r_out_valid} + {1'b0, r_skid_valid}
                     + {1'b0, r_s1_valid & r_s1_last};
    assign o_ready   = (w_pending < 2'd2) | w_pop;
    assign w_accept  = i_valid & o_ready;

    assign w_act       = (r_pos < PW'(MAX_LEN));
    assign w_ovf       = r_too_long | ~w_act;
    assign n_bal       = i_char_code[0] ? r_bal - BW'(1) : r_bal + BW'(1);
    assign w_seen      = r_any && (n_bal >= r_lo) && (n_bal <= r_hi);
    assign w_slot_full = BW'(n_bal) + BW'(MAX_LEN);
    assign w_slot      = w_slot_full[SW-1:0];
    assign w_pos_idx   = r_pos[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal      <= '0;
            r_lo       <= '0;
            r_hi       <= '0;
            r_any      <= 1'b0;
            r_pos      <= '0;
            r_too_long <= 1'b0;
        end else if (w_accept) begin
            if (i_last) begin
                r_bal      <= '0;
                r_lo       <= '0;
                r_hi       <= '0;
                r_any      <= 1'b0;
                r_pos      <= '0;
                r_too_long <= 1'b0;
            end else begin
                r_too_long <= w_ovf;
                if (w_act) begin
                    r_bal <= n_bal;
                    r_pos <= r_pos + PW'(1);
                    r_any <= 1'b1;
                    // reached balances stay contiguous: only the ends move
                    if (!r_any || n_bal < r_lo) begin
                        r_lo <= n_bal;
                    end
                    if (!r_any || n_bal > r_hi) begin
                        r_hi <= n_bal;
                    end
                end
            end
        end
    end

    // first-seen memory: one read or one write per accepted word within MAX_LEN
    always_ff @(posedge i_clk) begin
        if (w_accept && w_act) begin
            if (w_seen) begin
                r_rd <= mem[w_slot];
            end else begin
                mem[w_slot] <= w_pos_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s1_act   <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s1_last  <= w_accept & i_last;
            r_s1_act   <= w_accept & w_act;
        end
        r_s1_seen <= w_seen;
        r_s1_zero <= (n_bal == '0);
        r_s1_ovf  <= w_ovf;
        r_s1_pos  <= w_pos_idx;
    end

    // check stage: zero balance first, then the distance to the first sighting
    assign w_len = PW'(r_s1_pos) - PW'(r_rd);

    always_comb begin
        n_best_len   = r_best_len;
        n_best_start = r_best_start;
        if (r_s1_act) begin
            if (r_s1_zero) begin
                n_best_len   = PW'(r_s1_pos) + PW'(1);
                n_best_start = '0;
            end
            if (r_s1_seen && w_len > n_best_len) begin
                n_best_len   = w_len;
                n_best_start = r_rd + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_len   <= '0;
            r_best_start <= '0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_best_len   <= '0;
                r_best_start <= '0;
            end else begin
                r_best_len   <= n_best_len;
                r_best_start <= n_best_start;
            end
        end
    end

    assign w_res.found      = (n_best_len != '0);
    assign w_res.run_start  = lbr_pkg::START_W'(n_best_start);
    assign w_res.run_length = lbr_pkg::LEN_W'(n_best_len);
    assign w_res.overflow   = r_s1_ovf;

    assign w_push = r_s1_valid & r_s1_last;
    assign w_pop  = r_out_valid & i_ready;

    // two-word result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= w_push;
                if (w_push) begin
                    r_skid <= w_res;
                end
            end else begin
                r_out_valid <= w_push;
                if (w_push) begin
                    r_out <= w_res;
                end
            end
        end else if (w_push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid       <= w_res;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out.found;
    assign o_run_start  = r_out.run_start;
    assign o_run_length = r_out.run_length;
    assign o_overflow   = r_out.overflow;

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && r_out_valid && r_skid_valid && !w_pop))
        else $error("result pushed into a full buffer");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_lo <= r_hi))
        else $error("reached balance range inverted");

    a_pos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_LEN))
        else $error("position ran past the limit");

    a_first_before: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_act && r_s1_seen) |-> (r_rd < r_s1_pos))
        else $error("first sighting not before current position");

endmodule
